FILE: rtl/acdi_pkg.sv
// ----------------------------------------------------------------------------
// acdi_pkg
// shared types and constants of the ata dma command issuer
// ----------------------------------------------------------------------------
package acdi_pkg;

    // taskfile and data port codes on target_port
    localparam logic [3:0] PORT_NONE     = 4'd0;
    localparam logic [3:0] PORT_FEATURES = 4'd1;
    localparam logic [3:0] PORT_COUNT0   = 4'd2;
    localparam logic [3:0] PORT_LBA0     = 4'd3;
    localparam logic [3:0] PORT_LBA1     = 4'd4;
    localparam logic [3:0] PORT_LBA2     = 4'd5;
    localparam logic [3:0] PORT_DEVSEL   = 4'd6;
    localparam logic [3:0] PORT_COMMAND  = 4'd7;
    localparam logic [3:0] PORT_COUNT1   = 4'd8;
    localparam logic [3:0] PORT_LBA3     = 4'd9;
    localparam logic [3:0] PORT_LBA4     = 4'd10;
    localparam logic [3:0] PORT_LBA5     = 4'd11;
    localparam logic [3:0] PORT_CONTROL  = 4'd12;
    localparam logic [3:0] PORT_DATA     = 4'd13;

    // configuration register indexes
    localparam logic [2:0] CFG_ATAPI   = 3'd0;
    localparam logic [2:0] CFG_DRIVE   = 3'd1;
    localparam logic [2:0] CFG_LBA28   = 3'd2;
    localparam logic [2:0] CFG_LBA48   = 3'd3;
    localparam logic [2:0] CFG_SECTORS = 3'd4;

    // command opcodes
    localparam logic [7:0] CMD_READ_DMA      = 8'hc8;
    localparam logic [7:0] CMD_WRITE_DMA     = 8'hca;
    localparam logic [7:0] CMD_READ_DMA_EXT  = 8'h25;
    localparam logic [7:0] CMD_WRITE_DMA_EXT = 8'h35;
    localparam logic [7:0] CMD_PACKET        = 8'ha0;
    localparam logic [7:0] SCSI_READ12       = 8'ha8;
    localparam logic [7:0] DEVSEL_CHS        = 8'ha0;
    localparam logic [7:0] DEVSEL_LBA        = 8'he0;

    localparam int unsigned SECTORS_PER_TRACK = 63;
    // reciprocal of 63 scaled by 2^34, exact for any 28-bit dividend
    localparam int unsigned RECIP_SHIFT = 34;
    localparam logic [28:0] RECIP_63 = 29'd272696337;

    // sequence lengths
    localparam logic [3:0] LEN_REJECT = 4'd1;
    localparam logic [3:0] LEN_ATAPI  = 4'd13;
    localparam logic [3:0] LEN_LBA48  = 4'd11;
    localparam logic [3:0] LEN_SHORT  = 4'd7;

    typedef enum logic [1:0] {
        MODE_CHS   = 2'd0,
        MODE_LBA28 = 2'd1,
        MODE_LBA48 = 2'd2
    } t_mode;

    typedef struct packed {
        logic        atapi;
        logic        drive;
        logic        lba28;
        logic        lba48;
        logic [31:0] sectors;
    } t_cfg;

    // decoded request handed to the emitter
    typedef struct packed {
        logic        rejected;
        logic        atapi;
        t_mode       mode;
        logic        is_write;
        logic        drive;
        logic [31:0] lba;
        logic [7:0]  count;
        logic [22:0] track;  // lba / 63
    } t_desc;

endpackage

FILE: rtl/acdi_cfg.sv
// ----------------------------------------------------------------------------
// acdi_cfg
// configuration register bank
// ----------------------------------------------------------------------------
module acdi_cfg
    import acdi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_cfg_ready,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ATAPI:   r_cfg.atapi   <= i_cfg_data[0];
                CFG_DRIVE:   r_cfg.drive   <= i_cfg_data[0];
                CFG_LBA28:   r_cfg.lba28   <= i_cfg_data[0];
                CFG_LBA48:   r_cfg.lba48   <= i_cfg_data[0];
                CFG_SECTORS: r_cfg.sectors <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: rtl/acdi_decode.sv
// ----------------------------------------------------------------------------
// acdi_decode
// request register, acceptance checks, addressing mode and chs divide
// ----------------------------------------------------------------------------
module acdi_decode
    import acdi_pkg::*;
#(
    parameter int unsigned BUFFER_BYTES = 65536
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [31:0] i_start_block,
    input  logic [7:0]  i_block_count,
    input  logic        i_desc_done,
    output logic        o_desc_valid,
    output t_desc       o_desc
);

    localparam logic [31:0] MAX_ATA   = 32'(BUFFER_BYTES / 512);
    localparam logic [31:0] MAX_ATAPI = 32'(BUFFER_BYTES / 2048);

    logic        r_req_valid;
    logic        r_kind;
    logic [31:0] r_lba;
    logic [7:0]  r_count;
    logic        r_desc_valid;
    t_desc       r_desc;

    logic        desc_free;
    logic        accept;
    logic        reject;
    logic [31:0] count32;
    logic [56:0] product;
    t_desc       n_desc;

    assign desc_free  = !r_desc_valid || i_desc_done;
    assign o_in_stall = r_req_valid && !desc_free;
    assign accept     = i_in_valid && !o_in_stall;

    assign count32 = {24'd0, r_count};
    assign product = {28'd0, r_lba[27:0]} * {28'd0, RECIP_63};

    always_comb begin
        reject = (r_count == 8'd0);
        if (i_cfg.atapi) begin
            if (count32 > MAX_ATAPI || r_kind) reject = 1'b1;
        end else begin
            if (count32 > MAX_ATA) reject = 1'b1;
            if (r_lba >= i_cfg.sectors || count32 > (i_cfg.sectors - r_lba)) reject = 1'b1;
            if (r_lba[31:28] != 4'd0 && !i_cfg.lba48) reject = 1'b1;
        end

        n_desc.rejected = reject;
        n_desc.atapi    = i_cfg.atapi;
        n_desc.is_write = r_kind;
        n_desc.drive    = i_cfg.drive;
        n_desc.lba      = r_lba;
        n_desc.count    = r_count;
        n_desc.track    = product[56:RECIP_SHIFT];
        priority if (r_lba[31:28] != 4'd0) n_desc.mode = MODE_LBA48;
        else if (i_cfg.lba28)              n_desc.mode = MODE_LBA28;
        else                               n_desc.mode = MODE_CHS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid  <= 1'b0;
            r_desc_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_req_valid <= 1'b1;
            end else if (desc_free) begin
                r_req_valid <= 1'b0;
            end
            if (desc_free) begin
                r_desc_valid <= r_req_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= i_kind;
            r_lba   <= i_start_block;
            r_count <= i_block_count;
        end
        if (desc_free && r_req_valid) begin
            r_desc <= n_desc;
        end
    end

    assign o_desc_valid = r_desc_valid;
    assign o_desc       = r_desc;

endmodule

FILE: rtl/acdi_emit.sv
// ----------------------------------------------------------------------------
// acdi_emit
// steps through the register write sequence into the output register
// ----------------------------------------------------------------------------
module acdi_emit
    import acdi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_desc_valid,
    input  t_desc       i_desc,
    output logic        o_desc_done,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_target_port,
    output logic [15:0] o_write_value,
    output logic        o_last_write,
    output logic        o_rejected
);

    logic        r_out_valid;
    logic [3:0]  r_port;
    logic [15:0] r_value;
    logic        r_last;
    logic        r_rej;
    logic [3:0]  r_step;

    logic        slot_free;
    logic        emit;
    logic [3:0]  seq_len;
    logic        is_last;
    logic [3:0]  slot;
    logic [3:0]  n_port;
    logic [7:0]  n_byte;
    logic [15:0] n_value;
    logic [28:0] track63;
    logic [28:0] rem;
    logic [5:0]  sector;
    logic [7:0]  devsel;
    logic [7:0]  cmd;
    logic [7:0]  drv;

    assign slot_free   = !r_out_valid || !i_out_stall;
    assign emit        = i_desc_valid && slot_free;
    assign is_last     = (r_step == seq_len - 4'd1);
    assign o_desc_done = emit && is_last;

    // chs: sector from the remainder, cylinder and head from the track number
    assign track63 = {i_desc.track, 6'd0} - {6'd0, i_desc.track};
    assign rem     = {1'b0, i_desc.lba[27:0]} - track63;
    assign sector  = rem[5:0] + 6'd1;
    assign drv     = {3'd0, i_desc.drive, 4'd0};

    always_comb begin
        priority if (i_desc.rejected)           seq_len = LEN_REJECT;
        else if (i_desc.atapi)                  seq_len = LEN_ATAPI;
        else if (i_desc.mode == MODE_LBA48)     seq_len = LEN_LBA48;
        else                                    seq_len = LEN_SHORT;

        // short sequences skip the four high-order writes
        if (r_step < 4'd2 || i_desc.mode == MODE_LBA48) slot = r_step;
        else                                            slot = r_step + 4'd4;

        unique case (i_desc.mode)
            MODE_CHS:   devsel = DEVSEL_CHS | drv | {4'd0, i_desc.track[3:0]};
            MODE_LBA28: devsel = DEVSEL_LBA | drv | {4'd0, i_desc.lba[27:24]};
            MODE_LBA48: devsel = DEVSEL_LBA | drv;
            default:    devsel = DEVSEL_LBA | drv;
        endcase

        if (i_desc.is_write) begin
            cmd = (i_desc.mode == MODE_LBA48) ? CMD_WRITE_DMA_EXT : CMD_WRITE_DMA;
        end else begin
            cmd = (i_desc.mode == MODE_LBA48) ? CMD_READ_DMA_EXT : CMD_READ_DMA;
        end

        n_port  = PORT_NONE;
        n_byte  = 8'd0;
        n_value = 16'd0;
        if (i_desc.rejected) begin
            n_port  = PORT_NONE;
            n_value = 16'd0;
        end else if (i_desc.atapi) begin
            unique case (r_step)
                4'd0: begin n_port = PORT_CONTROL; n_value = 16'd2; end
                4'd1: begin n_port = PORT_DEVSEL;  n_value = {8'd0, drv}; end
                4'd2: begin n_port = PORT_FEATURES; n_value = 16'd1; end
                // transfer byte count is count * 2048, low byte always zero
                4'd3: begin n_port = PORT_LBA1; n_value = 16'd0; end
                4'd4: begin n_port = PORT_LBA2; n_value = {8'd0, i_desc.count[4:0], 3'd0}; end
                4'd5: begin n_port = PORT_COMMAND; n_value = {8'd0, CMD_PACKET}; end
                4'd6: begin n_port = PORT_CONTROL; n_value = 16'd0; end
                4'd7: begin n_port = PORT_DATA; n_value = {8'd0, SCSI_READ12}; end
                4'd8: begin
                    n_port  = PORT_DATA;
                    n_value = {i_desc.lba[23:16], i_desc.lba[31:24]};
                end
                4'd9: begin
                    n_port  = PORT_DATA;
                    n_value = {i_desc.lba[7:0], i_desc.lba[15:8]};
                end
                4'd10: begin n_port = PORT_DATA; n_value = 16'd0; end
                4'd11: begin n_port = PORT_DATA; n_value = {i_desc.count, 8'd0}; end
                default: begin n_port = PORT_DATA; n_value = 16'd0; end
            endcase
        end else begin
            unique case (slot)
                4'd0: begin n_port = PORT_CONTROL; n_byte = 8'd0; end
                4'd1: begin n_port = PORT_DEVSEL;  n_byte = devsel; end
                4'd2: begin n_port = PORT_COUNT1;  n_byte = 8'd0; end
                4'd3: begin n_port = PORT_LBA3;    n_byte = i_desc.lba[31:24]; end
                4'd4: begin n_port = PORT_LBA4;    n_byte = 8'd0; end
                4'd5: begin n_port = PORT_LBA5;    n_byte = 8'd0; end
                4'd6: begin n_port = PORT_COUNT0;  n_byte = i_desc.count; end
                4'd7: begin
                    n_port = PORT_LBA0;
                    n_byte = (i_desc.mode == MODE_CHS) ? {2'd0, sector} : i_desc.lba[7:0];
                end
                4'd8: begin
                    n_port = PORT_LBA1;
                    n_byte = (i_desc.mode == MODE_CHS) ? i_desc.track[11:4]
                                                       : i_desc.lba[15:8];
                end
                4'd9: begin
                    n_port = PORT_LBA2;
                    n_byte = (i_desc.mode == MODE_CHS) ? i_desc.track[19:12]
                                                       : i_desc.lba[23:16];
                end
                default: begin n_port = PORT_COMMAND; n_byte = cmd; end
            endcase
            n_value = {8'd0, n_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_step      <= 4'd0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
            r_step      <= is_last ? 4'd0 : r_step + 4'd1;
        end else if (slot_free) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_port  <= n_port;
            r_value <= n_value;
            r_last  <= is_last;
            r_rej   <= i_desc.rejected;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_target_port = r_port;
    assign o_write_value = r_value;
    assign o_last_write  = r_last;
    assign o_rejected    = r_rej;

endmodule

FILE: rtl/ata_dma_command_issuer_unit.sv
// a request passes the request register and the descriptor register before its first write is registered
// throughput: one write per cycle while i_out_stall is low; a request gives 13 writes (atapi),
// 11 (lba48), 7 (lba28 or chs) or 1 (rejected), all through the single output register
// a new request is taken while the previous one is still being written out
// reset: synchronous active low, clears configuration to zero and empties all stages
// ----------------------------------------------------------------------------
// ata_dma_command_issuer_unit
// builds the ordered taskfile and packet writes for one dma read or write request
// ----------------------------------------------------------------------------
module ata_dma_command_issuer_unit
    import acdi_pkg::*;
#(
    parameter int unsigned BUFFER_BYTES = 65536
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [31:0] i_start_block,
    input  logic [7:0]  i_block_count,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_target_port,
    output logic [15:0] o_write_value,
    output logic        o_last_write,
    output logic        o_rejected
);

    t_cfg  cfg;
    t_desc desc;
    logic  desc_valid;
    logic  desc_done;

    acdi_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    acdi_decode #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_start_block (i_start_block),
        .i_block_count (i_block_count),
        .i_desc_done   (desc_done),
        .o_desc_valid  (desc_valid),
        .o_desc        (desc)
    );

    acdi_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_desc_valid  (desc_valid),
        .i_desc        (desc),
        .o_desc_done   (desc_done),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_target_port (o_target_port),
        .o_write_value (o_write_value),
        .o_last_write  (o_last_write),
        .o_rejected    (o_rejected)
    );

endmodule

FILE: rtl/acdi_checker.sv
// ----------------------------------------------------------------------------
// acdi_checker
// port level checks on the command issuer output stream
// ----------------------------------------------------------------------------
module acdi_checker
    import acdi_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [3:0]  o_target_port,
    input logic [15:0] o_write_value,
    input logic        o_last_write,
    input logic        o_rejected
);

    // output stage is empty straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a refusal is a single zero result that closes the request
    a_reject_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rejected |->
            o_last_write && o_target_port == PORT_NONE && o_write_value == 16'd0)
        else $error("malformed rejection result");

    // an issued sequence ends on the command register or the packet data
    a_last_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_write && !o_rejected |->
            o_target_port == PORT_COMMAND || o_target_port == PORT_DATA)
        else $error("sequence ends on wrong register");

    // a stalled transfer holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_target_port) && $stable(o_write_value)
            && $stable(o_last_write) && $stable(o_rejected))
        else $error("stalled output changed");

endmodule

bind ata_dma_command_issuer_unit acdi_checker u_acdi_checker (.*);
